// File: rtl/sfcs_pkg.sv
// shared types, constants and tables for the frame check and split unit
// no dependencies; imported by every module of the unit
`timescale 1ns / 1ps
`default_nettype none

package sfcs_pkg;

    // frame geometry
    localparam int FRAME_BITS   = 80;
    localparam int BYTE_BITS    = 8;
    localparam int FRAME_BYTES  = FRAME_BITS / BYTE_BITS;
    localparam int DATA_END     = 64;
    localparam int LAST_START   = 60;
    localparam int FIRST_ID_POS = 2;
    localparam int ID_BITS      = 4;
    localparam int PAYLOAD_MAX  = 58;
    localparam int LEN_W        = 6;
    localparam int POS_W        = 7;

    // crc geometry
    localparam int CRC_WIDTH = 12;
    localparam int CRC_REG   = 16;
    localparam int CRC_DATA  = 68;
    localparam int CRC_SPLIT = CRC_DATA / 2;
    localparam int CRC_FLUSH = 16;
    localparam logic [CRC_REG-1:0]   CRC_POLY = 16'hD010;
    localparam logic [CRC_WIDTH-1:0] CRC_XOR  = 12'h955;

    // result status codes
    localparam logic [2:0] ST_PAYLOAD  = 3'd0;
    localparam logic [2:0] ST_CRC_FAIL = 3'd1;
    localparam logic [2:0] ST_NOT_INFO = 3'd2;
    localparam logic [2:0] ST_BAD_ID   = 3'd3;
    localparam logic [2:0] ST_NO_ROOM  = 3'd4;

    localparam logic [LEN_W-1:0] NO_LEN = '0;

    typedef struct packed {
        logic [63:0] frame_low;
        logic [15:0] frame_high;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]             status;
        logic [ID_BITS-1:0]     message_id;
        logic [LEN_W-1:0]       payload_length;
        logic [PAYLOAD_MAX-1:0] payload_bits;
        logic                   last;
    } t_out_beat;

    // after byte reorder and partial crc
    typedef struct packed {
        logic [FRAME_BITS-1:0] bits;
        logic [CRC_WIDTH-1:0]  crc_part_a;
        logic [CRC_WIDTH-1:0]  crc_part_b;
    } t_s1;

    // after crc compare and id decode
    typedef struct packed {
        logic                   crc_ok;
        logic                   not_info;
        logic                   two;
        logic                   has2;
        logic                   room2;
        logic [ID_BITS-1:0]     id1;
        logic [LEN_W-1:0]       len1;
        logic [PAYLOAD_MAX-1:0] win1;
        logic [ID_BITS-1:0]     id2;
        logic [LEN_W-1:0]       len2;
        logic [PAYLOAD_MAX-1:0] win2;
    } t_dec;

    // both results of one frame
    typedef struct packed {
        t_out_beat first;
        t_out_beat second;
        logic      two;
    } t_pair;

    // payload length per message id
    function automatic logic [LEN_W-1:0] len_of(input logic [ID_BITS-1:0] id);
        logic [LEN_W-1:0] len;
        case (id)
            4'd0:    len = 6'd32;
            4'd1:    len = 6'd22;
            4'd2:    len = 6'd58;
            4'd3:    len = 6'd32;
            4'd4:    len = 6'd27;
            4'd5:    len = 6'd58;
            4'd6:    len = 6'd27;
            4'd7:    len = 6'd22;
            4'd8:    len = 6'd58;
            4'd9:    len = 6'd58;
            4'd10:   len = 6'd27;
            default: len = NO_LEN;
        endcase
        return len;
    endfunction

    // crc contribution of each data bit on its own, flush shifts included
    function automatic logic [CRC_DATA*CRC_WIDTH-1:0] crc_matrix();
        logic [CRC_DATA*CRC_WIDTH-1:0] m;
        logic [CRC_REG-1:0]            crc;
        logic                          low;
        m = '0;
        for (int b = 0; b < CRC_DATA; b++) begin
            crc = '0;
            for (int j = CRC_DATA - 1; j >= 0; j--) begin
                low = crc[0];
                crc = crc >> 1;
                if (j == b) begin
                    crc[CRC_REG-1] = ~crc[CRC_REG-1];
                end
                if (low) begin
                    crc = crc ^ CRC_POLY;
                end
            end
            for (int z = 0; z < CRC_FLUSH; z++) begin
                low = crc[0];
                crc = crc >> 1;
                if (low) begin
                    crc = crc ^ CRC_POLY;
                end
            end
            m[b*CRC_WIDTH +: CRC_WIDTH] = crc[CRC_WIDTH-1:0];
        end
        return m;
    endfunction

    localparam logic [CRC_DATA*CRC_WIDTH-1:0] CRC_MATRIX = crc_matrix();

endpackage

`default_nettype wire

// File: rtl/sis_frame_check_and_split_unit.sv
// top level: crc checked frame payload splitter, four register stages
// depends on sfcs_pkg, sfcs_check, sfcs_decode, sfcs_extract, sfcs_split
//
//  channel | direction | handshake                | beat
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in_beat  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall| o_out_beat (t_out_beat)
//
// a frame enters every cycle while o_in_stall is low; a frame with one result
// leaves one beat, one with two results holds the output register for a
// second beat, so the single output register sets the frame rate.
// synchronous active-low reset clears only the stage valid bits and the pending flag.
// a stall on the out channel freezes each stage whose following stages all hold frames.
`timescale 1ns / 1ps
`default_nettype none

module sis_frame_check_and_split_unit
    import sfcs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_beat i_in_beat,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_beat     o_out_beat
);

    logic  s1_valid;
    logic  s1_stall;
    t_s1   s1_data;
    logic  s2_valid;
    logic  s2_stall;
    t_dec  s2_data;
    logic  s3_valid;
    logic  s3_stall;
    t_pair s3_data;

    sfcs_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_beat  (i_in_beat),
        .o_stall (o_in_stall),
        .o_valid (s1_valid),
        .o_data  (s1_data),
        .i_stall (s1_stall)
    );

    sfcs_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_stall (s1_stall),
        .o_valid (s2_valid),
        .o_data  (s2_data),
        .i_stall (s2_stall)
    );

    sfcs_extract u_extract (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_stall (s2_stall),
        .o_valid (s3_valid),
        .o_data  (s3_data),
        .i_stall (s3_stall)
    );

    sfcs_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .i_pair  (s3_data),
        .o_stall (s3_stall),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat),
        .i_stall (i_out_stall)
    );

    // error results always close the frame
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != ST_PAYLOAD) |-> o_out_beat.last)
        else $error("error result without last");

    // error results carry no id, length or bits
    a_error_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != ST_PAYLOAD)
        |-> (o_out_beat.message_id == '0) && (o_out_beat.payload_length == '0)
            && (o_out_beat.payload_bits == '0))
        else $error("error result with payload fields set");

    // a payload result always has a table length
    a_payload_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status == ST_PAYLOAD)
        |-> (o_out_beat.payload_length != NO_LEN))
        else $error("payload result with zero length");

    // the second result of a frame follows the first with no gap
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_beat.last |=> o_out_valid)
        else $error("second result of a frame missing");

endmodule

`default_nettype wire

// File: rtl/sfcs_check.sv
// stage 1: byte-wise bit reversal of the frame and two partial crc sums
// depends on sfcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfcs_check
    import sfcs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_beat i_beat,
    output logic          o_stall,
    output logic          o_valid,
    output t_s1           o_data,
    input  wire logic     i_stall
);

    logic [FRAME_BITS-1:0] raw;
    t_s1                   n_data;
    t_s1                   r_data;
    logic                  r_valid;

    assign raw = {i_beat.frame_high, i_beat.frame_low};

    // reverse bits in each byte, then xor the per-bit crc columns per half
    always_comb begin
        n_data = '0;
        for (int b = 0; b < FRAME_BYTES; b++) begin
            for (int k = 0; k < BYTE_BITS; k++) begin
                n_data.bits[b*BYTE_BITS + k] = raw[b*BYTE_BITS + BYTE_BITS - 1 - k];
            end
        end
        for (int i = 0; i < CRC_SPLIT; i++) begin
            if (n_data.bits[i]) begin
                n_data.crc_part_a = n_data.crc_part_a ^ CRC_MATRIX[i*CRC_WIDTH +: CRC_WIDTH];
            end
        end
        for (int i = CRC_SPLIT; i < CRC_DATA; i++) begin
            if (n_data.bits[i]) begin
                n_data.crc_part_b = n_data.crc_part_b ^ CRC_MATRIX[i*CRC_WIDTH +: CRC_WIDTH];
            end
        end
    end

    assign o_stall = r_valid & i_stall;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/sfcs_decode.sv
// stage 2: crc compare, id and length lookup for both payload slots,
// payload windows aligned msb first; depends on sfcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfcs_decode
    import sfcs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_s1  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_dec      o_data,
    input  wire logic i_stall
);

    logic [CRC_WIDTH-1:0] want;
    logic [DATA_END-1:0]  dm;
    logic [DATA_END-1:0]  sh2;
    logic [POS_W-1:0]     pos2;
    logic [ID_BITS-1:0]   id1;
    logic [LEN_W-1:0]     len1;
    t_dec                 n_data;
    t_dec                 r_data;
    logic                 r_valid;

    // received crc, first bit most significant
    always_comb begin
        for (int j = 0; j < CRC_WIDTH; j++) begin
            want[CRC_WIDTH-1-j] = i_data.bits[CRC_DATA + j];
        end
    end

    // data region in msb-first order: frame position p sits at bit 63-p
    always_comb begin
        for (int i = 0; i < DATA_END; i++) begin
            dm[DATA_END-1-i] = i_data.bits[i];
        end
    end

    // first slot id and its table length
    assign id1  = dm[DATA_END-1-FIRST_ID_POS -: ID_BITS];
    assign len1 = len_of(id1);

    // second slot starts right after the first payload
    assign pos2 = POS_W'(FIRST_ID_POS + ID_BITS) + POS_W'(len1);
    assign sh2  = dm << pos2;

    always_comb begin
        n_data          = '0;
        n_data.crc_ok   = ((i_data.crc_part_a ^ i_data.crc_part_b ^ CRC_XOR) == want);
        n_data.not_info = i_data.bits[0];
        n_data.two      = i_data.bits[1];
        n_data.id1      = id1;
        n_data.len1     = len1;
        n_data.win1     = dm[DATA_END-1-FIRST_ID_POS-ID_BITS -: PAYLOAD_MAX];
        n_data.has2     = (pos2 <= POS_W'(LAST_START));
        n_data.id2      = sh2[DATA_END-1 -: ID_BITS];
        n_data.len2     = len_of(n_data.id2);
        n_data.win2     = sh2[DATA_END-1-ID_BITS -: PAYLOAD_MAX];
        n_data.room2    = ((pos2 + POS_W'(ID_BITS) + POS_W'(n_data.len2))
                           <= POS_W'(DATA_END));
    end

    assign o_stall = r_valid & i_stall;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/sfcs_extract.sv
// stage 3: payload right alignment and forming of the one or two results
// depends on sfcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfcs_extract
    import sfcs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_dec i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_pair     o_data,
    input  wire logic i_stall
);

    logic [PAYLOAD_MAX-1:0] bits1;
    logic [PAYLOAD_MAX-1:0] bits2;
    t_pair                  n_data;
    t_pair                  r_data;
    logic                   r_valid;

    // drop the window bits beyond each payload length
    assign bits1 = i_data.win1 >> (LEN_W'(PAYLOAD_MAX) - i_data.len1);
    assign bits2 = i_data.win2 >> (LEN_W'(PAYLOAD_MAX) - i_data.len2);

    // result selection in the order the checks apply
    always_comb begin
        n_data = '0;
        n_data.first.last = 1'b1;
        if (!i_data.crc_ok) begin
            n_data.first.status = ST_CRC_FAIL;
        end else if (i_data.not_info) begin
            n_data.first.status = ST_NOT_INFO;
        end else if (i_data.len1 == NO_LEN) begin
            n_data.first.status = ST_BAD_ID;
        end else begin
            n_data.first.status         = ST_PAYLOAD;
            n_data.first.message_id     = i_data.id1;
            n_data.first.payload_length = i_data.len1;
            n_data.first.payload_bits   = bits1;
            if (i_data.two && i_data.has2) begin
                n_data.first.last  = 1'b0;
                n_data.two         = 1'b1;
                n_data.second.last = 1'b1;
                if (i_data.len2 == NO_LEN) begin
                    n_data.second.status = ST_BAD_ID;
                end else if (!i_data.room2) begin
                    n_data.second.status = ST_NO_ROOM;
                end else begin
                    n_data.second.status         = ST_PAYLOAD;
                    n_data.second.message_id     = i_data.id2;
                    n_data.second.payload_length = i_data.len2;
                    n_data.second.payload_bits   = bits2;
                end
            end
        end
    end

    assign o_stall = r_valid & i_stall;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/sfcs_split.sv
// output register that sends the one or two results of a frame as beats
// depends on sfcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfcs_split
    import sfcs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_pair i_pair,
    output logic       o_stall,
    output logic       o_valid,
    output t_out_beat  o_beat,
    input  wire logic  i_stall
);

    logic      r_valid;
    logic      r_pend;
    t_out_beat r_beat;
    t_out_beat r_next;
    logic      out_take;
    logic      can_load;

    assign out_take = r_valid & ~i_stall;
    // a new frame loads when empty or once the last beat of the held one leaves
    assign can_load = ~r_valid | (out_take & ~r_pend);
    assign o_stall  = ~can_load;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (can_load) begin
            r_valid <= i_valid;
            r_pend  <= i_valid & i_pair.two;
        end else if (out_take) begin
            r_pend <= 1'b0;
        end
    end

    // beat and the waiting second result
    always_ff @(posedge i_clk) begin
        if (can_load && i_valid) begin
            r_beat <= i_pair.first;
            r_next <= i_pair.second;
        end else if (out_take && r_pend) begin
            r_beat <= r_next;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire
